FILE: rtl/nursery_bump_fragment_allocator_macros.svh
// Assertion helpers; each expects clock and reset in scope.
`ifndef NURSERY_BUMP_FRAGMENT_ALLOCATOR_MACROS_SVH
`define NURSERY_BUMP_FRAGMENT_ALLOCATOR_MACROS_SVH

`define NBFA_ASSERT_NOW(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define NBFA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nbfa_pkg.sv
package nbfa_pkg;

   localparam int HEADER_BYTES  = 8;
   localparam int MAX_FRAGMENTS = 16;
   localparam int MAX_PINNED    = 16;
   localparam int IDX_W         = $clog2(MAX_FRAGMENTS);
   localparam int CNT_W         = IDX_W + 1;
   localparam int TOTAL_W       = 34;

   localparam logic [31:0] MIN_FRAG      = 32'(HEADER_BYTES + 8);
   localparam logic [31:0] NURSERY_RESET = 32'd4194304;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_PIN   = 2'd1;
   localparam logic [1:0] FUNC_RESET = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_RESET_DONE = 2'd3;

   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_NURSERY   = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] request_bytes;
      logic [15:0] type_tag;
      logic [47:0] pin_address;
      logic [28:0] pin_units;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] payload_address;
      logic [47:0] header_address;
      logic [28:0] size_units;
      logic [15:0] header_type;
      logic        from_fragment;
      logic [31:0] used_bytes;
      logic [4:0]  fragment_count;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LATCH, CMD_BUMP, CMD_TAKE, CMD_FAIL, CMD_SHIFT, CMD_DROP, CMD_PIN,
      CMD_NOP, CMD_RST_INIT, CMD_SORT_LOAD, CMD_SORT_STEP, CMD_SORT_END, CMD_GAP_STEP,
      CMD_GAP_END, CMD_RESP
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] ridx;
      logic [IDX_W-1:0] widx;
   } ctl_type;

   typedef struct packed {
      logic [1:0]       func;
      logic             bump_fit;
      logic             frag_fit;
      logic             frag_small;
      logic             swapped;
      logic [CNT_W-1:0] fcnt;
      logic [CNT_W-1:0] pcnt;
   } sts_type;

endpackage

FILE: rtl/nbfa_ctrl.sv
`include "nursery_bump_fragment_allocator_macros.svh"

module nbfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nbfa_pkg::sts_type sts,
   output nbfa_pkg::ctl_type ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_RST, S_SORT_LOAD, S_SORT_STEP, S_GAP, S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [nbfa_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [nbfa_pkg::CNT_W-1:0]  idx_next;
   logic [nbfa_pkg::CNT_W-1:0]  idx_prev;

   assign idx_next = idx_ff + nbfa_pkg::CNT_W'(1);
   assign idx_prev = idx_ff - nbfa_pkg::CNT_W'(1);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ctl.cmd  = nbfa_pkg::CMD_NONE;
      ctl.ridx = idx_ff[nbfa_pkg::IDX_W-1:0];
      ctl.widx = idx_ff[nbfa_pkg::IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.cmd  = nbfa_pkg::CMD_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.func)
               nbfa_pkg::FUNC_ALLOC: begin
                  if (sts.bump_fit) begin
                     ctl.cmd  = nbfa_pkg::CMD_BUMP;
                     state_in = S_DONE;
                  end else begin
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               nbfa_pkg::FUNC_PIN: begin
                  ctl.cmd  = nbfa_pkg::CMD_PIN;
                  state_in = S_DONE;
               end
               nbfa_pkg::FUNC_RESET: begin
                  state_in = S_RST;
               end
               default: begin
                  ctl.cmd  = nbfa_pkg::CMD_NOP;
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (idx_ff >= sts.fcnt) begin
               ctl.cmd  = nbfa_pkg::CMD_FAIL;
               state_in = S_DONE;
            end else if (sts.frag_fit) begin
               ctl.cmd  = nbfa_pkg::CMD_TAKE;
               state_in = sts.frag_small ? S_SHIFT : S_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_SHIFT: begin
            if (idx_next < sts.fcnt) begin
               ctl.cmd  = nbfa_pkg::CMD_SHIFT;
               ctl.ridx = idx_next[nbfa_pkg::IDX_W-1:0];
               idx_in   = idx_next;
            end else begin
               ctl.cmd  = nbfa_pkg::CMD_DROP;
               state_in = S_DONE;
            end
         end
         S_RST: begin
            ctl.cmd = nbfa_pkg::CMD_RST_INIT;
            idx_in  = '0;
            if (sts.pcnt == '0) begin
               state_in = S_DONE;
            end else if (sts.pcnt == nbfa_pkg::CNT_W'(1)) begin
               state_in = S_GAP;
            end else begin
               state_in = S_SORT_LOAD;
            end
         end
         S_SORT_LOAD: begin
            ctl.cmd  = nbfa_pkg::CMD_SORT_LOAD;
            ctl.ridx = '0;
            idx_in   = nbfa_pkg::CNT_W'(1);
            state_in = S_SORT_STEP;
         end
         S_SORT_STEP: begin
            ctl.widx = idx_prev[nbfa_pkg::IDX_W-1:0];
            if (idx_ff < sts.pcnt) begin
               ctl.cmd = nbfa_pkg::CMD_SORT_STEP;
               idx_in  = idx_next;
            end else begin
               ctl.cmd = nbfa_pkg::CMD_SORT_END;
               if (sts.swapped) begin
                  state_in = S_SORT_LOAD;
               end else begin
                  idx_in   = '0;
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            if (idx_ff < sts.pcnt) begin
               ctl.cmd = nbfa_pkg::CMD_GAP_STEP;
               idx_in  = idx_next;
            end else begin
               ctl.cmd  = nbfa_pkg::CMD_GAP_END;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            ctl.cmd  = nbfa_pkg::CMD_RESP;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   `NBFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
   `NBFA_ASSERT_NEXT(a_resp_idle, ctl.cmd == nbfa_pkg::CMD_RESP, !busy, "no return to idle")
   `NBFA_ASSERT_NOW(a_scan_bound, (state_ff != S_SCAN) || (idx_ff <= sts.fcnt), "scan overran")

endmodule

FILE: rtl/nbfa_datapath.sv
`include "nursery_bump_fragment_allocator_macros.svh"

module nbfa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [47:0]       csr_wdata,
   input  nbfa_pkg::req_type req_item,
   input  nbfa_pkg::ctl_type ctl,
   output nbfa_pkg::sts_type sts,
   output nbfa_pkg::rsp_type rsp_item,
   output logic              rsp_valid
);

   localparam int TW = nbfa_pkg::TOTAL_W;
   localparam int CW = nbfa_pkg::CNT_W;

   logic [47:0]   heap_base_ff;
   logic [31:0]   nursery_ff;
   logic [31:0]   bump_ff;
   logic [31:0]   used_ff;
   logic          bump_dis_ff;
   logic [CW-1:0] fcnt_ff;
   logic [CW-1:0] pcnt_ff;
   logic [31:0]   frag_start_ff [nbfa_pkg::MAX_FRAGMENTS];
   logic [31:0]   frag_size_ff  [nbfa_pkg::MAX_FRAGMENTS];
   logic [31:0]   pin_start_ff  [nbfa_pkg::MAX_PINNED];
   logic [31:0]   pin_len_ff    [nbfa_pkg::MAX_PINNED];
   nbfa_pkg::req_type req_ff;
   logic [TW-1:0] total_ff;
   logic [31:0]   hdr_ff;
   logic          hit_ff;
   logic          alloc_ok_ff;
   logic [1:0]    st_ff;
   logic [31:0]   cur_start_ff;
   logic [31:0]   cur_len_ff;
   logic          swapped_ff;
   logic [31:0]   prev_ff;
   logic [31:0]   sum_ff;
   logic          full_ff;
   logic [31:0]   first_ff;
   nbfa_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   logic [TW-1:0] total_in;
   logic [31:0]   rd_fs, rd_fz, rd_ps, rd_pl;
   logic [TW-1:0] bump_sum;
   logic [31:0]   rem;
   logic [34:0]   used_add;
   logic [31:0]   used_sat;
   logic [47:0]   pin_hdr, pin_off;
   logic [32:0]   g_e;
   logic [31:0]   g_sc, g_ec, gap_len, prev_next, end_len, end_bump;
   logic          gap_ok, end_ok, fcnt_full;
   logic [32:0]   sum_add;
   logic [31:0]   sum_sat;
   logic [47:0]   hdr_addr;

   assign total_in = ({2'b0, req_item.request_bytes} + TW'(nbfa_pkg::HEADER_BYTES + 7))
                     & ~TW'(7);
   assign rd_fs = frag_start_ff[ctl.ridx];
   assign rd_fz = frag_size_ff[ctl.ridx];
   assign rd_ps = pin_start_ff[ctl.ridx];
   assign rd_pl = pin_len_ff[ctl.ridx];

   assign bump_sum = {2'b0, bump_ff} + total_ff;
   assign rem      = rd_fz - total_ff[31:0];
   assign used_add = {3'b0, used_ff} + {1'b0, total_ff};
   assign used_sat = (used_add[34:32] != 3'b0) ? '1 : used_add[31:0];

   assign pin_hdr = req_ff.pin_address - 48'(nbfa_pkg::HEADER_BYTES);
   assign pin_off = pin_hdr - heap_base_ff;

   assign g_e       = {1'b0, rd_ps} + {1'b0, rd_pl};
   assign g_sc      = (rd_ps > nursery_ff) ? nursery_ff : rd_ps;
   assign g_ec      = (g_e > {1'b0, nursery_ff}) ? nursery_ff : g_e[31:0];
   assign gap_len   = g_sc - prev_ff;
   assign gap_ok    = (g_sc > prev_ff) && (gap_len >= nbfa_pkg::MIN_FRAG);
   assign prev_next = (g_ec > prev_ff) ? g_ec : prev_ff;
   assign sum_add   = {1'b0, sum_ff} + {1'b0, rd_pl};
   assign sum_sat   = sum_add[32] ? '1 : sum_add[31:0];
   assign end_len   = nursery_ff - prev_ff;
   assign end_ok    = (prev_ff < nursery_ff) && (end_len >= nbfa_pkg::MIN_FRAG);
   assign fcnt_full = (fcnt_ff == CW'(nbfa_pkg::MAX_FRAGMENTS));
   assign end_bump  = (fcnt_ff != '0) ? first_ff : (end_ok ? prev_ff : nursery_ff);

   assign hdr_addr = heap_base_ff + {16'b0, hdr_ff};

   assign sts.func       = req_ff.func;
   assign sts.bump_fit   = !bump_dis_ff && (bump_sum <= {2'b0, nursery_ff});
   assign sts.frag_fit   = ({2'b0, rd_fz} >= total_ff);
   assign sts.frag_small = (rem < nbfa_pkg::MIN_FRAG);
   assign sts.swapped    = swapped_ff;
   assign sts.fcnt       = fcnt_ff;
   assign sts.pcnt       = pcnt_ff;

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         nursery_ff   <= nbfa_pkg::NURSERY_RESET;
         bump_ff      <= '0;
         used_ff      <= '0;
         bump_dis_ff  <= 1'b0;
         fcnt_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               nbfa_pkg::CSR_HEAP_BASE: heap_base_ff <= csr_wdata;
               nbfa_pkg::CSR_NURSERY:   nursery_ff   <= csr_wdata[31:0];
               default: ;
            endcase
         end
         case (ctl.cmd)
            nbfa_pkg::CMD_LATCH: begin
               req_ff      <= req_item;
               total_ff    <= total_in;
               alloc_ok_ff <= 1'b0;
               hit_ff      <= 1'b0;
            end
            nbfa_pkg::CMD_BUMP: begin
               hdr_ff      <= bump_ff;
               bump_ff     <= bump_sum[31:0];
               used_ff     <= used_sat;
               alloc_ok_ff <= 1'b1;
               st_ff       <= nbfa_pkg::ST_OK;
            end
            nbfa_pkg::CMD_TAKE: begin
               hdr_ff                   <= rd_fs;
               frag_start_ff[ctl.widx]  <= rd_fs + total_ff[31:0];
               frag_size_ff[ctl.widx]   <= rem;
               used_ff                  <= used_sat;
               alloc_ok_ff              <= 1'b1;
               hit_ff                   <= 1'b1;
               st_ff                    <= nbfa_pkg::ST_OK;
            end
            nbfa_pkg::CMD_FAIL: begin
               st_ff <= nbfa_pkg::ST_NO_SPACE;
            end
            nbfa_pkg::CMD_SHIFT: begin
               frag_start_ff[ctl.widx] <= rd_fs;
               frag_size_ff[ctl.widx]  <= rd_fz;
            end
            nbfa_pkg::CMD_DROP: begin
               fcnt_ff <= fcnt_ff - CW'(1);
            end
            nbfa_pkg::CMD_PIN: begin
               if (pcnt_ff >= CW'(nbfa_pkg::MAX_PINNED)) begin
                  st_ff <= nbfa_pkg::ST_TABLE_FULL;
               end else if (req_ff.pin_address < 48'(nbfa_pkg::HEADER_BYTES) ||
                            pin_hdr < heap_base_ff || pin_off >= {16'b0, nursery_ff}) begin
                  st_ff <= nbfa_pkg::ST_NO_SPACE;
               end else begin
                  pin_start_ff[pcnt_ff[nbfa_pkg::IDX_W-1:0]] <= pin_off[31:0];
                  pin_len_ff[pcnt_ff[nbfa_pkg::IDX_W-1:0]]   <= {req_ff.pin_units, 3'b0};
                  pcnt_ff <= pcnt_ff + CW'(1);
                  st_ff   <= nbfa_pkg::ST_OK;
               end
            end
            nbfa_pkg::CMD_NOP: begin
               st_ff <= nbfa_pkg::ST_OK;
            end
            nbfa_pkg::CMD_RST_INIT: begin
               fcnt_ff <= '0;
               prev_ff <= '0;
               sum_ff  <= '0;
               full_ff <= 1'b0;
               st_ff   <= nbfa_pkg::ST_RESET_DONE;
               if (pcnt_ff == '0) begin
                  bump_ff     <= '0;
                  used_ff     <= '0;
                  bump_dis_ff <= 1'b0;
               end
            end
            nbfa_pkg::CMD_SORT_LOAD: begin
               cur_start_ff <= rd_ps;
               cur_len_ff   <= rd_pl;
               swapped_ff   <= 1'b0;
            end
            nbfa_pkg::CMD_SORT_STEP: begin
               if (cur_start_ff > rd_ps) begin
                  pin_start_ff[ctl.widx] <= rd_ps;
                  pin_len_ff[ctl.widx]   <= rd_pl;
                  swapped_ff             <= 1'b1;
               end else begin
                  pin_start_ff[ctl.widx] <= cur_start_ff;
                  pin_len_ff[ctl.widx]   <= cur_len_ff;
                  cur_start_ff           <= rd_ps;
                  cur_len_ff             <= rd_pl;
               end
            end
            nbfa_pkg::CMD_SORT_END: begin
               pin_start_ff[ctl.widx] <= cur_start_ff;
               pin_len_ff[ctl.widx]   <= cur_len_ff;
            end
            nbfa_pkg::CMD_GAP_STEP: begin
               sum_ff  <= sum_sat;
               prev_ff <= prev_next;
               if (gap_ok) begin
                  if (fcnt_full) begin
                     full_ff <= 1'b1;
                  end else begin
                     frag_start_ff[fcnt_ff[nbfa_pkg::IDX_W-1:0]] <= prev_ff;
                     frag_size_ff[fcnt_ff[nbfa_pkg::IDX_W-1:0]]  <= gap_len;
                     fcnt_ff <= fcnt_ff + CW'(1);
                     if (fcnt_ff == '0) begin
                        first_ff <= prev_ff;
                     end
                  end
               end
            end
            nbfa_pkg::CMD_GAP_END: begin
               bump_ff     <= end_bump;
               bump_dis_ff <= 1'b1;
               used_ff     <= sum_ff;
               if (end_ok && fcnt_full) begin
                  st_ff <= nbfa_pkg::ST_TABLE_FULL;
               end else begin
                  st_ff <= full_ff ? nbfa_pkg::ST_TABLE_FULL : nbfa_pkg::ST_RESET_DONE;
                  if (end_ok) begin
                     frag_start_ff[fcnt_ff[nbfa_pkg::IDX_W-1:0]] <= prev_ff;
                     frag_size_ff[fcnt_ff[nbfa_pkg::IDX_W-1:0]]  <= end_len;
                     fcnt_ff <= fcnt_ff + CW'(1);
                  end
               end
            end
            nbfa_pkg::CMD_RESP: begin
               rsp_valid_ff          <= 1'b1;
               rsp_ff.status         <= st_ff;
               rsp_ff.used_bytes     <= used_ff;
               rsp_ff.fragment_count <= fcnt_ff;
               if (alloc_ok_ff) begin
                  rsp_ff.payload_address <= hdr_addr + 48'(nbfa_pkg::HEADER_BYTES);
                  rsp_ff.header_address  <= hdr_addr;
                  rsp_ff.size_units      <= total_ff[31:3];
                  rsp_ff.header_type     <= req_ff.type_tag;
                  rsp_ff.from_fragment   <= hit_ff;
               end else begin
                  rsp_ff.payload_address <= '0;
                  rsp_ff.header_address  <= '0;
                  rsp_ff.size_units      <= '0;
                  rsp_ff.header_type     <= '0;
                  rsp_ff.from_fragment   <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   `NBFA_ASSERT_NOW(a_fcnt_max, fcnt_ff <= CW'(nbfa_pkg::MAX_FRAGMENTS), "fragment count overflow")
   `NBFA_ASSERT_NOW(a_pcnt_max, pcnt_ff <= CW'(nbfa_pkg::MAX_PINNED), "pin count overflow")

endmodule

FILE: rtl/nursery_bump_fragment_allocator.sv
// Nursery allocator with a bump pointer and first-fit free fragments. Each request taken on
// start (while busy is low) gives one result, shown on rsp_item for exactly one cycle with
// rsp_valid high; the receiver cannot stall it. An allocation that the bump pointer cannot serve
// scans the fragments in order from the first (a miss passes over all of them) and takes the
// first that fits; when the remainder of the used fragment is too small, the fragment is
// dropped and every entry behind it is moved up. A reset with n pins sorts the single-ported
// pin table by start in bubble passes (up to n passes) and then builds gaps at one pin per
// cycle. busy is high from acceptance until the result cycle. Configuration registers may be
// written whenever busy is low.
`include "nursery_bump_fragment_allocator_macros.svh"

module nursery_bump_fragment_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nbfa_pkg::req_type req_item,
   output nbfa_pkg::rsp_type rsp_item,
   output logic              rsp_valid,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [47:0]       csr_wdata
);

   nbfa_pkg::ctl_type ctl;
   nbfa_pkg::sts_type sts;

   nbfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   nbfa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

   `NBFA_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")

endmodule
